### rtl/tce_pkg.sv
// ----------------------------------------------------------------------------
// tce_pkg: shared types and constants of the tricorn escape-time unit
// Fixed-point widths, port layout constants and the Q8.24 saturation helper.
// ----------------------------------------------------------------------------
package tce_pkg;

  // Fixed-point value and product widths
  localparam int Q_W    = 32;
  localparam int PROD_W = 2 * Q_W;
  localparam int SAT_W  = PROD_W + 2;

  // Defaults of the top-level parameters
  localparam int FRAC_BITS_DEF = 24;
  localparam int ITER_BITS_DEF = 16;

  // Register and result field widths
  localparam int MAX_ITER_W = 16;
  localparam logic [MAX_ITER_W-1:0] MAX_ITER_RST = 16'd256;
  localparam int COUNT_W = 16;
  localparam int NORM_W  = 31;
  localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

  // Stream data widths (whole bytes)
  localparam int IN_TDATA_W  = 2 * Q_W;
  localparam int OUT_FIELD_W = COUNT_W + 2 * Q_W + NORM_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Saturation limits of a Q value, held wide
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(64'sd2147483647);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_W'(64'sd2147483648);

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Clamp a wide signed value to the Q range
  function automatic q_t sat_q(input logic signed [SAT_W-1:0] v);
    q_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[Q_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/tce_mul.sv
// ----------------------------------------------------------------------------
// tce_mul: shared signed multiplier
// One 32x32 signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module tce_mul (
  input  logic           clk,
  input  tce_pkg::q_t    a,
  input  tce_pkg::q_t    b,
  output tce_pkg::prod_t prod
);
  import tce_pkg::*;

  // Register the full-width product
  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

### rtl/tce_step.sv
// ----------------------------------------------------------------------------
// tce_step: iteration arithmetic
// Builds the next z from the stored products and forms the norm test of z.
// ----------------------------------------------------------------------------
module tce_step #(
  parameter int FRAC_BITS = tce_pkg::FRAC_BITS_DEF
) (
  input  tce_pkg::prod_t              pxx,
  input  tce_pkg::prod_t              pyy,
  input  tce_pkg::prod_t              pxy,
  input  tce_pkg::q_t                 cr,
  input  tce_pkg::q_t                 ci,
  output tce_pkg::q_t                 x_next,
  output tce_pkg::q_t                 y_next,
  input  tce_pkg::prod_t              sq_x,
  input  tce_pkg::prod_t              sq_y,
  output logic                        escaped,
  output logic [tce_pkg::NORM_W-1:0]  norm_sat
);
  import tce_pkg::*;

  localparam int SUM_W = PROD_W - FRAC_BITS;
  localparam logic [SUM_W-1:0] FOUR = SUM_W'(1) << (FRAC_BITS + 2);

  q_t xx;
  q_t yy;
  q_t sr;
  q_t si;
  logic signed [SAT_W-1:0] neg_xy;
  logic [SUM_W-1:0] norm_sum;

  // Floor the squares and the negated doubled cross term, then add c
  always_comb begin
    xx     = sat_q(SAT_W'(pxx >>> FRAC_BITS));
    yy     = sat_q(SAT_W'(pyy >>> FRAC_BITS));
    sr     = sat_q(SAT_W'(xx) - SAT_W'(yy));
    neg_xy = -SAT_W'(pxy);
    si     = sat_q(neg_xy >>> (FRAC_BITS - 1));
    x_next = sat_q(SAT_W'(sr) + SAT_W'(cr));
    y_next = sat_q(SAT_W'(si) + SAT_W'(ci));
  end

  // Sum the floored squares exactly; squares are never negative
  always_comb begin
    norm_sum = SUM_W'(sq_x[PROD_W-2:FRAC_BITS]) + SUM_W'(sq_y[PROD_W-2:FRAC_BITS]);
    escaped  = norm_sum > FOUR;
    if (norm_sum > SUM_W'(NORM_MAX)) begin
      norm_sat = NORM_MAX;
    end else begin
      norm_sat = norm_sum[NORM_W-1:0];
    end
  end

endmodule

### rtl/tricorn_escape_time_unit.sv
// Throughput: one point at a time; the next beat is taken only once the
// previous result has been loaded into the output register. Each iteration
// runs one update and then three products through the single shared 32x32
// multiplier. Reset sets max_iter to 256, returns the sequencer to idle and
// drops any pending result.
// ----------------------------------------------------------------------------
// tricorn_escape_time_unit: tricorn escape-time tracer
// Iterates z = conj(z)^2 + c in Q8.24 until |z|^2 > 4 or the limit is hit.
// ----------------------------------------------------------------------------
module tricorn_escape_time_unit #(
  parameter int FRAC_BITS = tce_pkg::FRAC_BITS_DEF,
  parameter int ITER_BITS = tce_pkg::ITER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [tce_pkg::MAX_ITER_W-1:0]  cfg_wr_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: c_re [31:0], c_im [63:32]
  input  logic [tce_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: iter_count [15:0], esc_re [47:16], esc_im [79:48],
  //          esc_norm [110:80], zero pad [111]
  output logic [tce_pkg::OUT_TDATA_W-1:0] m_tdata,
  // m_tuser: inside_set [0]
  output logic                            m_tuser
);
  import tce_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_MXX  = 3'd2;
  localparam logic [2:0] S_MYY  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]            state;
  logic [MAX_ITER_W-1:0] max_iter;
  logic [ITER_BITS-1:0]  limit;
  logic [ITER_BITS-1:0]  n;
  logic [ITER_BITS-1:0]  res_cnt;
  logic                  in_set;
  logic [NORM_W-1:0]     norm_r;
  q_t                    x;
  q_t                    y;
  q_t                    cr;
  q_t                    ci;
  prod_t                 pxx;
  prod_t                 pyy;
  prod_t                 prod;
  q_t                    mul_a;
  q_t                    mul_b;
  q_t                    x_next;
  q_t                    y_next;
  logic                  escaped;
  logic [NORM_W-1:0]     norm_sat;
  logic                  in_beat;
  logic                  out_load;
  logic                  last_iter;

  assign limit     = ITER_BITS'(max_iter);
  assign s_tready  = (state == S_IDLE);
  assign in_beat   = s_tvalid && s_tready;
  assign out_load  = (state == S_DONE) && (!m_tvalid || m_tready);
  assign last_iter = (n == limit - ITER_BITS'(1));

  // Hold the iteration limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= MAX_ITER_RST;
    end else if (cfg_wr_en) begin
      max_iter <= cfg_wr_data;
    end
  end

  // Pick multiplier operands per step: x*x, y*y, x*y, zero in the other states
  always_comb begin
    unique case (state)
      S_MXX: begin
        mul_a = x;
        mul_b = x;
      end
      S_MYY: begin
        mul_a = y;
        mul_b = y;
      end
      S_CHK: begin
        mul_a = x;
        mul_b = y;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tce_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  tce_step #(
    .FRAC_BITS (FRAC_BITS)
  ) u_step (
    .pxx      (pxx),
    .pyy      (pyy),
    .pxy      (prod),
    .cr       (cr),
    .ci       (ci),
    .x_next   (x_next),
    .y_next   (y_next),
    .sq_x     (pxx),
    .sq_y     (prod),
    .escaped  (escaped),
    .norm_sat (norm_sat)
  );

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            state <= (limit == '0) ? S_DONE : S_UPD;
          end
        end
        S_UPD:  state <= S_MXX;
        S_MXX:  state <= S_MYY;
        S_MYY:  state <= S_CHK;
        S_CHK: begin
          if (escaped || last_iter) begin
            state <= S_DONE;
          end else begin
            state <= S_UPD;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers of the iteration
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cr      <= s_tdata[Q_W-1:0];
      ci      <= s_tdata[2*Q_W-1:Q_W];
      x       <= '0;
      y       <= '0;
      pxx     <= '0;
      pyy     <= '0;
      n       <= '0;
      res_cnt <= '0;
      in_set  <= 1'b1;
      norm_r  <= '0;
    end else begin
      unique case (state)
        S_UPD: begin
          x <= x_next;
          y <= y_next;
        end
        S_MYY: pxx <= prod;
        S_CHK: begin
          pyy    <= prod;
          norm_r <= norm_sat;
          n      <= n + ITER_BITS'(1);
          if (escaped) begin
            res_cnt <= n;
            in_set  <= 1'b0;
          end else if (last_iter) begin
            res_cnt <= limit;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: load when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_TDATA_W'({norm_r, y, x, COUNT_W'(res_cnt)});
      m_tuser <= in_set;
    end
  end

  // A beat starts an iteration, or finishes at once on a zero limit
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == S_UPD) || (state == S_DONE))
    else $error("accepted beat did not start the sequencer");

  // A check that neither escapes nor ends goes on to the next update
  a_continue: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) && !escaped && !last_iter |=>
      (state == S_UPD) && (n == $past(n) + ITER_BITS'(1)))
    else $error("iteration did not advance");

  // The counter stays below the limit while iterating
  a_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> (n < limit))
    else $error("iteration counter ran past the limit");

  // A finished point lands in the output register
  a_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid && (state == S_IDLE))
    else $error("finished result not presented");

  // The sequencer holds a finished result in done while the output is stalled
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && m_tvalid && !m_tready |=> (state == S_DONE))
    else $error("result dropped while output stalled");

endmodule
